// ===== hw/rtl/complex_arith_unit_defines.svh =====
// Shared assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Check an implication in the same cycle, held off while in reset.
`define CAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle, held off while in reset.
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned ProdWidth = 2 * DataWidth;
  localparam int unsigned SumWidth  = ProdWidth + 1;
  localparam int unsigned MulWidth  = SumWidth - FracBits;
  localparam int unsigned QuotWidth = DataWidth;
  localparam int unsigned NumCells  = QuotWidth;
  localparam int unsigned NumWidth  = ProdWidth + FracBits;

  localparam logic [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } cau_status_e;

  // One quotient lane as it moves down the divider chain
  typedef struct packed {
    logic [ProdWidth-1:0] rem;
    logic [QuotWidth-1:0] nlow;
    logic [QuotWidth-1:0] quo;
    logic                 neg;
    logic                 ovf;
  } cau_lane_t;

  typedef struct packed {
    logic                 is_div;
    logic [DataWidth-1:0] pass_re;
    logic [DataWidth-1:0] pass_im;
    cau_status_e          pass_st;
    logic [ProdWidth-1:0] den;
    cau_lane_t            lane_re;
    cau_lane_t            lane_im;
  } cau_cell_t;

endpackage

// ===== hw/rtl/complex_arith_unit.sv =====
// From request acceptance to the result on the outputs, the pipeline runs through
// products, sums, magnitudes, then 32 divider cells, then the output register.
// Throughput: one request per cycle unless stalled; one quotient bit per cell.
// Every stage holds only while its successor is full and stalled.
// Reset (rst_ni low, asynchronous) empties the pipeline; payload is not cleared.
module complex_arith_unit
  import cau_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [1:0]                  operation_i,
  input  logic signed [DataWidth-1:0] a_re_i,
  input  logic signed [DataWidth-1:0] a_im_i,
  input  logic signed [DataWidth-1:0] b_re_i,
  input  logic signed [DataWidth-1:0] b_im_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [DataWidth-1:0] res_re_o,
  output logic signed [DataWidth-1:0] res_im_o,
  output logic [1:0]                  status_o
);

  // Stage 1: the six products, plus add/subtract finished outright
  typedef struct packed {
    cau_op_e              op;
    logic [ProdWidth-1:0] ac;
    logic [ProdWidth-1:0] bd;
    logic [ProdWidth-1:0] bc;
    logic [ProdWidth-1:0] ad;
    logic [ProdWidth-1:0] cc;
    logic [ProdWidth-1:0] dd;
    logic [DataWidth-1:0] as_re;
    logic [DataWidth-1:0] as_im;
    logic                 as_sat;
  } s1_t;

  // Stage 2: combined products and the divisor's squared magnitude
  typedef struct packed {
    cau_op_e              op;
    logic [SumWidth-1:0]  mre;
    logic [SumWidth-1:0]  mim;
    logic [SumWidth-1:0]  nre;
    logic [SumWidth-1:0]  nim;
    logic [ProdWidth-1:0] den;
    logic [DataWidth-1:0] as_re;
    logic [DataWidth-1:0] as_im;
    logic                 as_sat;
  } s2_t;

  // Stage 3: finished non-divide results, numerator magnitudes and signs
  typedef struct packed {
    logic                 is_div;
    logic [DataWidth-1:0] pass_re;
    logic [DataWidth-1:0] pass_im;
    cau_status_e          pass_st;
    logic [ProdWidth-1:0] den;
    logic [ProdWidth-1:0] mag_re;
    logic [ProdWidth-1:0] mag_im;
    logic                 neg_re;
    logic                 neg_im;
  } s3_t;

  typedef struct packed {
    logic [DataWidth-1:0] re;
    logic [DataWidth-1:0] im;
    cau_status_e          st;
  } res_t;

  // Clamp a sum that grew by one bit
  function automatic logic [DataWidth:0] sat_sum(input logic [DataWidth:0] v);
    if (v[DataWidth] != v[DataWidth-1]) begin
      return {1'b1, v[DataWidth] ? MinVal : MaxVal};
    end
    return {1'b0, v[DataWidth-1:0]};
  endfunction

  // Clamp a shifted product sum
  function automatic logic [DataWidth:0] sat_mul(input logic [MulWidth-1:0] v);
    if (&v[MulWidth-1:DataWidth-1] || ~|v[MulWidth-1:DataWidth-1]) begin
      return {1'b0, v[DataWidth-1:0]};
    end
    return {1'b1, v[MulWidth-1] ? MinVal : MaxVal};
  endfunction

  // Apply the sign to a quotient and clamp it
  function automatic logic [DataWidth:0] sat_quo(input cau_lane_t l);
    logic big;
    big = l.neg ? (l.quo[QuotWidth-1] && |l.quo[QuotWidth-2:0]) : l.quo[QuotWidth-1];
    if (l.ovf || big) begin
      return {1'b1, l.neg ? MinVal : MaxVal};
    end
    return {1'b0, l.neg ? DataWidth'(-l.quo) : DataWidth'(l.quo)};
  endfunction

  logic      v1_q, v2_q, v3_q, vo_q;
  logic      rdy1, rdy2, rdy3, rdy_out;
  s1_t       s1_q, s1_d;
  s2_t       s2_q, s2_d;
  s3_t       s3_q, s3_d;
  res_t      res_q, res_d;

  logic [NumCells:0] ch_v;
  logic [NumCells:0] ch_rdy;
  cau_cell_t         ch_d [NumCells+1];

  // Ready ripples back: a stage takes new data when empty or when it empties
  assign rdy_out = !vo_q || ready_i;
  assign rdy3    = !v3_q || ch_rdy[0];
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // Stage 1
  always_comb begin
    logic [DataWidth:0] sr, si, fr, fi;
    logic               sub;
    sub = (cau_op_e'(operation_i) == OP_SUB);
    sr  = sub ? (DataWidth+1)'(a_re_i) - (DataWidth+1)'(b_re_i)
              : (DataWidth+1)'(a_re_i) + (DataWidth+1)'(b_re_i);
    si  = sub ? (DataWidth+1)'(a_im_i) - (DataWidth+1)'(b_im_i)
              : (DataWidth+1)'(a_im_i) + (DataWidth+1)'(b_im_i);
    fr  = sat_sum(sr);
    fi  = sat_sum(si);
    s1_d.op     = cau_op_e'(operation_i);
    s1_d.ac     = a_re_i * b_re_i;
    s1_d.bd     = a_im_i * b_im_i;
    s1_d.bc     = a_im_i * b_re_i;
    s1_d.ad     = a_re_i * b_im_i;
    s1_d.cc     = b_re_i * b_re_i;
    s1_d.dd     = b_im_i * b_im_i;
    s1_d.as_re  = fr[DataWidth-1:0];
    s1_d.as_im  = fi[DataWidth-1:0];
    s1_d.as_sat = fr[DataWidth] || fi[DataWidth];
  end

  // Stage 2
  always_comb begin
    s2_d.op     = s1_q.op;
    s2_d.mre    = SumWidth'(signed'(s1_q.ac)) - SumWidth'(signed'(s1_q.bd));
    s2_d.mim    = SumWidth'(signed'(s1_q.bc)) + SumWidth'(signed'(s1_q.ad));
    s2_d.nre    = SumWidth'(signed'(s1_q.ac)) + SumWidth'(signed'(s1_q.bd));
    s2_d.nim    = SumWidth'(signed'(s1_q.bc)) - SumWidth'(signed'(s1_q.ad));
    s2_d.den    = s1_q.cc + s1_q.dd;
    s2_d.as_re  = s1_q.as_re;
    s2_d.as_im  = s1_q.as_im;
    s2_d.as_sat = s1_q.as_sat;
  end

  // Stage 3: settle everything except the quotient itself
  always_comb begin
    logic [DataWidth:0] mr, mi;
    logic [SumWidth-1:0] ar, ai;
    mr = sat_mul(s2_q.mre[SumWidth-1:FracBits]);
    mi = sat_mul(s2_q.mim[SumWidth-1:FracBits]);
    ar = s2_q.nre[SumWidth-1] ? -s2_q.nre : s2_q.nre;
    ai = s2_q.nim[SumWidth-1] ? -s2_q.nim : s2_q.nim;
    s3_d.is_div  = 1'b0;
    s3_d.pass_re = s2_q.as_re;
    s3_d.pass_im = s2_q.as_im;
    s3_d.pass_st = s2_q.as_sat ? ST_SAT : ST_OK;
    s3_d.den     = s2_q.den;
    s3_d.mag_re  = ar[ProdWidth-1:0];
    s3_d.mag_im  = ai[ProdWidth-1:0];
    s3_d.neg_re  = s2_q.nre[SumWidth-1];
    s3_d.neg_im  = s2_q.nim[SumWidth-1];
    unique case (s2_q.op)
      OP_ADD, OP_SUB: begin
      end
      OP_MUL: begin
        s3_d.pass_re = mr[DataWidth-1:0];
        s3_d.pass_im = mi[DataWidth-1:0];
        s3_d.pass_st = (mr[DataWidth] || mi[DataWidth]) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        // Zero divisor: drop the quotient and report it directly
        if (s2_q.den == '0) begin
          s3_d.pass_re = '0;
          s3_d.pass_im = '0;
          s3_d.pass_st = ST_DIVZ;
        end else begin
          s3_d.is_div = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Load the divider chain: the upper numerator bits seed the remainder, and a
  // quotient that cannot fit in the lane is flagged as overflow up front
  always_comb begin
    logic [NumWidth-1:0] nr, ni;
    nr = {s3_q.mag_re, {FracBits{1'b0}}};
    ni = {s3_q.mag_im, {FracBits{1'b0}}};
    ch_d[0].is_div       = s3_q.is_div;
    ch_d[0].pass_re      = s3_q.pass_re;
    ch_d[0].pass_im      = s3_q.pass_im;
    ch_d[0].pass_st      = s3_q.pass_st;
    ch_d[0].den          = s3_q.den;
    ch_d[0].lane_re.rem  = ProdWidth'(nr[NumWidth-1:QuotWidth]);
    ch_d[0].lane_re.nlow = nr[QuotWidth-1:0];
    ch_d[0].lane_re.quo  = '0;
    ch_d[0].lane_re.neg  = s3_q.neg_re;
    ch_d[0].lane_re.ovf  = (ProdWidth'(nr[NumWidth-1:QuotWidth]) >= s3_q.den);
    ch_d[0].lane_im.rem  = ProdWidth'(ni[NumWidth-1:QuotWidth]);
    ch_d[0].lane_im.nlow = ni[QuotWidth-1:0];
    ch_d[0].lane_im.quo  = '0;
    ch_d[0].lane_im.neg  = s3_q.neg_im;
    ch_d[0].lane_im.ovf  = (ProdWidth'(ni[NumWidth-1:QuotWidth]) >= s3_q.den);
  end

  assign ch_v[0]          = v3_q;
  assign ch_rdy[NumCells] = rdy_out;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    cau_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_v[k]),
      .ready_o (ch_rdy[k]),
      .data_i  (ch_d[k]),
      .valid_o (ch_v[k+1]),
      .ready_i (ch_rdy[k+1]),
      .data_o  (ch_d[k+1])
    );
  end

  // Output stage: sign and clamp the quotients, or pass the settled result
  always_comb begin
    logic [DataWidth:0] qr, qi;
    qr = sat_quo(ch_d[NumCells].lane_re);
    qi = sat_quo(ch_d[NumCells].lane_im);
    if (ch_d[NumCells].is_div) begin
      res_d.re = qr[DataWidth-1:0];
      res_d.im = qi[DataWidth-1:0];
      res_d.st = (qr[DataWidth] || qi[DataWidth]) ? ST_SAT : ST_OK;
    end else begin
      res_d.re = ch_d[NumCells].pass_re;
      res_d.im = ch_d[NumCells].pass_im;
      res_d.st = ch_d[NumCells].pass_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_out) begin
        vo_q <= ch_v[NumCells];
      end
    end
  end

  // Payload advances only with a request behind it
  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      s1_q <= s1_d;
    end
    if (v1_q && rdy2) begin
      s2_q <= s2_d;
    end
    if (v2_q && rdy3) begin
      s3_q <= s3_d;
    end
    if (ch_v[NumCells] && rdy_out) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = vo_q;
  assign res_re_o = res_q.re;
  assign res_im_o = res_q.im;
  assign status_o = res_q.st;

endmodule

// ===== hw/rtl/cau_cell.sv =====
module cau_cell
  import cau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cau_cell_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cau_cell_t data_o
);

  logic      v_q;
  cau_cell_t d_q;
  cau_cell_t d_d;

  // One restoring-division step: shift in the next numerator bit, subtract if it fits
  function automatic cau_lane_t lane_step(input cau_lane_t l, input logic [ProdWidth-1:0] den);
    logic [ProdWidth:0] t;
    logic [ProdWidth:0] diff;
    logic               qbit;
    cau_lane_t          r;
    t    = {l.rem, l.nlow[QuotWidth-1]};
    diff = t - {1'b0, den};
    qbit = (t >= {1'b0, den});
    r        = l;
    r.rem    = qbit ? diff[ProdWidth-1:0] : t[ProdWidth-1:0];
    r.nlow   = {l.nlow[QuotWidth-2:0], 1'b0};
    r.quo    = {l.quo[QuotWidth-2:0], qbit};
    return r;
  endfunction

  always_comb begin
    d_d         = data_i;
    d_d.lane_re = lane_step(data_i.lane_re, data_i.den);
    d_d.lane_im = lane_step(data_i.lane_im, data_i.den);
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

// ===== hw/rtl/cau_checker.sv =====
`include "complex_arith_unit_defines.svh"

module cau_checker
  import cau_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        valid_i,
  input logic                        ready_o,
  input logic [1:0]                  operation_i,
  input logic signed [DataWidth-1:0] a_re_i,
  input logic signed [DataWidth-1:0] a_im_i,
  input logic signed [DataWidth-1:0] b_re_i,
  input logic signed [DataWidth-1:0] b_im_i,
  input logic                        valid_o,
  input logic                        ready_i,
  input logic signed [DataWidth-1:0] res_re_o,
  input logic signed [DataWidth-1:0] res_im_o,
  input logic [1:0]                  status_o
);

  `CAU_ASSERT_IMPL(a_status_code, clk_i, rst_ni, valid_o, status_o != 2'd3,
    "status code out of range")
  `CAU_ASSERT_IMPL(a_divz_zero, clk_i, rst_ni, valid_o && (status_o == ST_DIVZ),
    (res_re_o == '0) && (res_im_o == '0), "divide by zero result not zero")
  `CAU_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && !ready_i,
    valid_o && $stable(res_re_o) && $stable(res_im_o) && $stable(status_o),
    "stalled result changed")
  `CAU_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, valid_i && !ready_o,
    valid_i && $stable(operation_i) && $stable(a_re_i) && $stable(a_im_i)
    && $stable(b_re_i) && $stable(b_im_i), "waiting request changed")
  `CAU_ASSERT_IMPL(a_empty_after_reset, clk_i, rst_ni, $rose(rst_ni), !valid_o,
    "result valid straight out of reset")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// ===== bench/complex_arith_unit_tb.sv =====
`timescale 1ns / 100ps

module complex_arith_unit_tb;
  import cau_pkg::*;

  // Expected result of one request: both parts and the status code.
  typedef struct packed {
    logic [DataWidth-1:0] re;
    logic [DataWidth-1:0] im;
    cau_status_e          st;
  } cplx_result_t;

  // Clamp a wide signed value into the data range; raise the overflow flag when clamped.
  function automatic logic [DataWidth-1:0] clamp_part(input logic signed [159:0] v,
                                                      inout bit ovf);
    logic signed [159:0] hi_lim;
    logic signed [159:0] lo_lim;
    hi_lim = 160'sd2147483647;
    lo_lim = -160'sd2147483648;
    if (v > hi_lim) begin
      ovf = 1'b1;
      return MaxVal;
    end
    if (v < lo_lim) begin
      ovf = 1'b1;
      return MinVal;
    end
    return v[DataWidth-1:0];
  endfunction

  // Divide with truncation toward zero after scaling the magnitude by the fraction bits.
  function automatic logic signed [159:0] fixed_quot(input logic signed [159:0] num,
                                                     input logic signed [159:0] den);
    logic signed [159:0] mag;
    logic signed [159:0] q;
    mag = (num < 0) ? -num : num;
    q   = (mag <<< FracBits) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cplx_result_t complex_result(input cau_op_e op,
                                                  input logic signed [DataWidth-1:0] ar,
                                                  input logic signed [DataWidth-1:0] ai,
                                                  input logic signed [DataWidth-1:0] br,
                                                  input logic signed [DataWidth-1:0] bi);
    logic signed [159:0] a, b, c, d, re, im, den;
    bit ovf;
    cplx_result_t r;
    a = ar; b = ai; c = br; d = bi;
    ovf = 1'b0;
    case (op)
      OP_ADD: begin
        re = a + c; im = b + d;
      end
      OP_SUB: begin
        re = a - c; im = b - d;
      end
      OP_MUL: begin
        re = (a * c - b * d) >>> FracBits;
        im = (b * c + a * d) >>> FracBits;
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.re = '0; r.im = '0; r.st = ST_DIVZ;
          return r;
        end
        re = fixed_quot(a * c + b * d, den);
        im = fixed_quot(b * c - a * d, den);
      end
    endcase
    r.re = clamp_part(re, ovf);
    r.im = clamp_part(im, ovf);
    r.st = ovf ? ST_SAT : ST_OK;
    return r;
  endfunction

  int unsigned mismatch_cnt = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Keep the results still owed by the block, oldest first.
  class cplx_scoreboard;
    cplx_result_t owed_q[$];

    function void note_request(cau_op_e op, logic [DataWidth-1:0] ar, logic [DataWidth-1:0] ai,
                               logic [DataWidth-1:0] br, logic [DataWidth-1:0] bi);
      owed_q.push_back(complex_result(op, ar, ai, br, bi));
    endfunction

    task check_result(logic [DataWidth-1:0] re, logic [DataWidth-1:0] im, logic [1:0] st);
      cplx_result_t e;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing owed");
        return;
      end
      e = owed_q.pop_front();
      if (re !== e.re)
        report_mismatch($sformatf("res_re %h, want %h", re, e.re));
      if (im !== e.im)
        report_mismatch($sformatf("res_im %h, want %h", im, e.im));
      if (st !== e.st)
        report_mismatch($sformatf("status %0d, want %0d", st, e.st));
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        valid_i = 1'b0;
  logic                        ready_o;
  logic [1:0]                  operation_i = '0;
  logic signed [DataWidth-1:0] a_re_i = '0;
  logic signed [DataWidth-1:0] a_im_i = '0;
  logic signed [DataWidth-1:0] b_re_i = '0;
  logic signed [DataWidth-1:0] b_im_i = '0;
  logic                        valid_o;
  logic                        ready_i = 1'b0;
  logic signed [DataWidth-1:0] res_re_o;
  logic signed [DataWidth-1:0] res_im_o;
  logic [1:0]                  status_o;

  complex_arith_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cplx_scoreboard sb = new();

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned RandomCount   = 830;

  // Hold the idling off during this stretch of cycles on both sides.
  int unsigned cycle_cnt = 0;
  int unsigned quiet_cnt = 0;
  function automatic bit calm_stretch();
    return cycle_cnt >= 300 && cycle_cnt < 500;
  endfunction

  // Sample both handshakes at the edge, before any new drive takes effect.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (valid_i && ready_o)
        sb.note_request(cau_op_e'(operation_i), a_re_i, a_im_i, b_re_i, b_im_i);
      if (valid_o && ready_i)
        sb.check_result(res_re_o, res_im_o, status_o);
      quiet_cnt <= ((valid_i && ready_o) || (valid_o && ready_i)) ? 0 : quiet_cnt + 1;
      if (quiet_cnt >= WatchdogLimit) begin
        $display("complex_arith_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // Result side: stall with a chance of 9 in 100, save in the calm stretch.
  always @(posedge clk_i)
    ready_i <= calm_stretch() || ($urandom_range(99) >= 9);

  // Pick a random part with a bias toward bounds, small values and wide values.
  function automatic logic [DataWidth-1:0] pick_part();
    case ($urandom_range(9))
      0: return MaxVal;
      1: return MinVal;
      2: return '0;
      3: return DataWidth'($signed($urandom_range(8)) - 4) << FracBits;
      4, 5: return DataWidth'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  // Present one request, idle at random first, and hold it until accepted.
  task automatic send_request(input cau_op_e op, input logic [DataWidth-1:0] ar,
                              input logic [DataWidth-1:0] ai, input logic [DataWidth-1:0] br,
                              input logic [DataWidth-1:0] bi);
    while (!calm_stretch() && $urandom_range(99) < 9) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    operation_i <= op;
    a_re_i      <= ar;
    a_im_i      <= ai;
    b_re_i      <= br;
    b_im_i      <= bi;
    do @(posedge clk_i); while (!ready_o);
  endtask

  initial begin
    cau_op_e op;
    logic [DataWidth-1:0] br, bi;
    int unsigned drain;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bounds for every operation, overflow both ways, zero divisor.
    for (int k = 0; k < 4; k++) begin
      op = cau_op_e'(k);
      send_request(op, MaxVal, MinVal, MaxVal, MinVal);
      send_request(op, MinVal, MinVal, MinVal, MinVal);
      send_request(op, 32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000);
      send_request(op, MaxVal, MaxVal, 32'h0000_0001, 32'hFFFF_FFFF);
    end
    send_request(OP_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0);
    send_request(OP_DIV, '0, '0, '0, '0);
    send_request(OP_DIV, MaxVal, MinVal, 32'h0000_0001, '0);
    send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003, '0);
    send_request(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    send_request(OP_ADD, MaxVal, '0, 32'h0000_0001, '0);
    send_request(OP_SUB, MinVal, '0, 32'h0000_0001, '0);

    // Random: one in twenty divides by zero, the rest spread over all operations.
    repeat (RandomCount) begin
      op = cau_op_e'($urandom_range(3));
      br = pick_part();
      bi = pick_part();
      if (op == OP_DIV && $urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_request(op, pick_part(), pick_part(), br, bi);
    end
    valid_i <= 1'b0;

    // Drain what is owed, then give the pipeline time to show any stray result.
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < DrainCycles; drain++) @(posedge clk_i);
    if (mismatch_cnt == 0 && sb.owed_q.size() == 0)
      $display("complex_arith_unit_tb: done, clean");
    else
      $display("complex_arith_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_cell.sv
hw/rtl/complex_arith_unit.sv
hw/rtl/cau_checker.sv
bench/complex_arith_unit_tb.sv
